### rtl/gfa_slp_pkg.sv
// Shared types and constants for the GFA segment length parser.
// Holds the request and result structs, the status codes and the byte constants.
// No dependencies.
package gfa_slp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    // Status codes of a result.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_SEGMENT = 3'd1;
    localparam logic [2:0] ST_MISSING     = 3'd2;
    localparam logic [2:0] ST_NO_TAG      = 3'd3;
    localparam logic [2:0] ST_BAD_NUMBER  = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd5;

    localparam logic [7:0] TAB_BYTE  = 8'h09;
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] SEG_BYTE  = 8'h53;
    localparam logic [7:0] ZERO_BYTE = 8'h30;
    localparam logic [7:0] NINE_BYTE = 8'h39;

    localparam logic [2:0] TAG_LEN      = 3'd5;
    localparam logic [2:0] TAG_MISMATCH = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       line_end;
    } char_req_t;

    typedef struct packed {
        logic [31:0] seg_length;
        logic [2:0]  status;
    } result_t;

    // Characters of the "LN:i:" tag by position.
    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h4C;
            3'd1:    ch = 8'h4E;
            3'd2:    ch = 8'h3A;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/gfa_segment_length_parser_core.sv
// Top level of the GFA segment length parser: byte stream in, one result per line out.
// Depends on gfa_slp_pkg for the request and result types and the status codes.
//
// The parser takes one text byte per request and accepts a request in every cycle
// except while a line end waits for a free output register. A request passes an
// input register, then updates the parse state while the result of a line end is
// formed and written to the output register, which drives the result port. The
// per-byte step is one multiply-by-ten-and-add on the 64-bit decimal accumulator,
// which sets the clock.
// A stall on the result side backs up into the input side only while a line end
// is waiting for a free output register.
module gfa_segment_length_parser_core #(
    parameter int LENGTH_BITS = gfa_slp_pkg::LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  gfa_slp_pkg::char_req_t char_req,
    output logic                   result_valid,
    input  logic                   result_stall,
    output gfa_slp_pkg::result_t   result_data
);
    import gfa_slp_pkg::*;

    localparam int SEQ_W = LENGTH_BITS + 1;

    // Input register.
    logic      s1_valid_reg;
    char_req_t s1_item_reg;
    logic      s1_go;
    logic      out_free;

    // Parse state.
    logic             line_pos_zero_reg, line_pos_zero_next;
    logic             is_segment_reg, is_segment_next;
    logic [1:0]       tab_count_reg, tab_count_next;
    logic [SEQ_W-1:0] seq_count_reg, seq_count_next;
    logic             seq_first_star_reg, seq_first_star_next;
    logic [2:0]       tag_pos_reg, tag_pos_next;
    logic             tag_found_reg, tag_found_next;
    logic             digits_active_reg, digits_active_next;
    logic             digit_seen_reg, digit_seen_next;
    logic [63:0]      number_reg, number_next;
    logic             overflow_reg, overflow_next;

    // Result register.
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t result_next;

    logic [7:0]  ch;
    logic        is_digit;
    logic [67:0] times_ten;
    logic [63:0] length_val;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_go      = s1_valid_reg && (!s1_item_reg.line_end || out_free);
    assign char_stall = s1_valid_reg && !s1_go;

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign ch        = s1_item_reg.data_byte;
    assign is_digit  = (ch >= ZERO_BYTE) && (ch <= NINE_BYTE);
    assign times_ten = {1'b0, number_reg, 3'b000} + {3'b000, number_reg, 1'b0}
                       + {60'd0, ch - ZERO_BYTE};

    // Byte step of the parse state.
    always_comb
    begin
        line_pos_zero_next  = line_pos_zero_reg;
        is_segment_next     = is_segment_reg;
        tab_count_next      = tab_count_reg;
        seq_count_next      = seq_count_reg;
        seq_first_star_next = seq_first_star_reg;
        tag_pos_next        = tag_pos_reg;
        tag_found_next      = tag_found_reg;
        digits_active_next  = digits_active_reg;
        digit_seen_next     = digit_seen_reg;
        number_next         = number_reg;
        overflow_next       = overflow_reg;

        if (s1_item_reg.byte_valid)
        begin
            if (line_pos_zero_reg)
            begin
                line_pos_zero_next = 1'b0;
                is_segment_next    = (ch == SEG_BYTE);
            end
            if (ch == TAB_BYTE)
            begin
                if (tab_count_reg != 2'd3)
                begin
                    tab_count_next = tab_count_reg + 2'd1;
                end
                else if (!tag_found_reg)
                begin
                    tag_pos_next = 3'd0;
                end
            end
            else if (tab_count_reg == 2'd2)
            begin
                if (seq_count_reg == '0)
                begin
                    seq_first_star_next = (ch == STAR_BYTE);
                end
                if (!seq_count_reg[SEQ_W-1])
                begin
                    seq_count_next = seq_count_reg + SEQ_W'(1);
                end
            end
            else if (tab_count_reg == 2'd3)
            begin
                // The first byte after a complete tag starts the digit run.
                if ((tag_found_reg && digits_active_reg) ||
                    (!tag_found_reg && tag_pos_reg == TAG_LEN))
                begin
                    tag_found_next     = 1'b1;
                    digits_active_next = 1'b1;
                    if (is_digit)
                    begin
                        overflow_next   = overflow_reg || (times_ten[67:64] != 4'd0);
                        number_next     = times_ten[63:0];
                        digit_seen_next = 1'b1;
                    end
                    else
                    begin
                        digits_active_next = 1'b0;
                    end
                end
                else if (!tag_found_reg && tag_pos_reg < TAG_LEN)
                begin
                    if (ch == tag_char(tag_pos_reg))
                    begin
                        tag_pos_next = tag_pos_reg + 3'd1;
                    end
                    else
                    begin
                        tag_pos_next = TAG_MISMATCH;
                    end
                end
            end
        end
    end

    // Line result from the state after this byte.
    always_comb
    begin
        length_val = 64'd0;
        if (line_pos_zero_next || !is_segment_next)
        begin
            result_next.status = ST_NOT_SEGMENT;
        end
        else if (tab_count_next < 2'd2)
        begin
            result_next.status = ST_MISSING;
        end
        else if (!(seq_count_next == SEQ_W'(1) && seq_first_star_next))
        begin
            if (seq_count_next[SEQ_W-1])
            begin
                result_next.status = ST_TOO_LARGE;
            end
            else
            begin
                result_next.status = ST_OK;
                length_val         = 64'(seq_count_next);
            end
        end
        else if (tab_count_next != 2'd3)
        begin
            result_next.status = ST_MISSING;
        end
        else if (!tag_found_next)
        begin
            result_next.status = ST_NO_TAG;
        end
        else if (!digit_seen_next || overflow_next)
        begin
            result_next.status = ST_BAD_NUMBER;
        end
        else if ((number_next >> LENGTH_BITS) != 64'd0)
        begin
            result_next.status = ST_TOO_LARGE;
        end
        else
        begin
            result_next.status = ST_OK;
            length_val         = number_next;
        end
        result_next.seg_length = length_val[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            s1_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            s1_item_reg <= char_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_zero_reg  <= 1'b1;
            is_segment_reg     <= 1'b0;
            tab_count_reg      <= 2'd0;
            seq_count_reg      <= '0;
            seq_first_star_reg <= 1'b0;
            tag_pos_reg        <= 3'd0;
            tag_found_reg      <= 1'b0;
            digits_active_reg  <= 1'b0;
            digit_seen_reg     <= 1'b0;
            number_reg         <= 64'd0;
            overflow_reg       <= 1'b0;
        end
        else if (s1_go)
        begin
            if (s1_item_reg.line_end)
            begin
                line_pos_zero_reg  <= 1'b1;
                is_segment_reg     <= 1'b0;
                tab_count_reg      <= 2'd0;
                seq_count_reg      <= '0;
                seq_first_star_reg <= 1'b0;
                tag_pos_reg        <= 3'd0;
                tag_found_reg      <= 1'b0;
                digits_active_reg  <= 1'b0;
                digit_seen_reg     <= 1'b0;
                number_reg         <= 64'd0;
                overflow_reg       <= 1'b0;
            end
            else
            begin
                line_pos_zero_reg  <= line_pos_zero_next;
                is_segment_reg     <= is_segment_next;
                tab_count_reg      <= tab_count_next;
                seq_count_reg      <= seq_count_next;
                seq_first_star_reg <= seq_first_star_next;
                tag_pos_reg        <= tag_pos_next;
                tag_found_reg      <= tag_found_next;
                digits_active_reg  <= digits_active_next;
                digit_seen_reg     <= digit_seen_next;
                number_reg         <= number_next;
                overflow_reg       <= overflow_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_item_reg.line_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_item_reg.line_end)
        begin
            out_data_reg <= result_next;
        end
    end

    // A line end must never be taken while the output register still holds a result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_item_reg.line_end) |-> out_free)
        else $error("line end taken while result register is occupied");

    // A result that is not ok carries a zero length.
    a_len_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_OK) |-> (out_data_reg.seg_length == 32'd0))
        else $error("nonzero length with error status");

    // A tag is only found inside the tag fields.
    a_tag_after_third_tab: assert property (@(posedge clk) disable iff (!rst_n)
        tag_found_reg |-> (tab_count_reg == 2'd3))
        else $error("tag found before the third tab");

    // The parse state starts over after every line end.
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_item_reg.line_end) |=> (line_pos_zero_reg && !tag_found_reg))
        else $error("parse state not cleared after line end");

endmodule

### sim/tb_gfa_segment_length_parser_core.sv
// Testbench for gfa_segment_length_parser_core: streams text lines one byte per request
// and checks each line's result against a parser model kept in the testbench.
// Depends on gfa_slp_pkg and the core RTL; reads no files.
`timescale 1ns / 1ps

module tb_gfa_segment_length_parser_core;
    import gfa_slp_pkg::*;

    localparam int          LEN_BITS   = LENGTH_BITS_DEF;
    localparam logic [63:0] LEN_MAX    = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [39:0] LN_TAG     = "LN:i:";
    localparam int          IDLE_LIMIT = 2000;
    localparam int          ITEM_GOAL  = 1400;

    typedef logic [7:0] octet_t;

    logic      clk;
    logic      rst_n;
    logic      char_valid;
    logic      char_stall;
    char_req_t char_req;
    logic      result_valid;
    logic      result_stall;
    result_t   result_data;

    // Parser model state: a single copy for the line being sent, cleared at each line end.
    logic        line_fresh;
    logic        line_is_seg;
    logic [1:0]  tab_cnt;
    logic [32:0] seq_len;
    logic        seq_star;
    logic [2:0]  tag_pos;
    logic        tag_hit;
    logic        in_digits;
    logic        any_digit;
    logic [63:0] ln_value;
    logic        ln_overflow;

    result_t line_results[$];
    octet_t  line_buf[$];
    int      errors     = 0;
    int      items_sent = 0;
    int      idle_cycles = 0;
    int      rx_hold    = 0;
    bit      gaps_on    = 1'b1;
    bit      rx_quiet   = 1'b0;

    gfa_segment_length_parser_core #(
        .LENGTH_BITS(LEN_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_req    (char_req),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_line();
        line_fresh  = 1'b1;
        line_is_seg = 1'b0;
        tab_cnt     = '0;
        seq_len     = '0;
        seq_star    = 1'b0;
        tag_pos     = '0;
        tag_hit     = 1'b0;
        in_digits   = 1'b0;
        any_digit   = 1'b0;
        ln_value    = '0;
        ln_overflow = 1'b0;
    endfunction

    function automatic void take_ln_digit(octet_t c);
        logic [63:0] d;
        d = {56'd0, c - ZERO_BYTE};
        if (c >= ZERO_BYTE && c <= NINE_BYTE)
        begin
            if (ln_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                ln_overflow = 1'b1;
            ln_value  = ln_value * 64'd10 + d;
            any_digit = 1'b1;
        end
        else
            in_digits = 1'b0;
    endfunction

    function automatic void take_line_byte(octet_t c);
        if (line_fresh)
        begin
            line_fresh  = 1'b0;
            line_is_seg = (c == SEG_BYTE);
        end
        if (c == TAB_BYTE)
        begin
            if (tab_cnt < 2'd3)
                tab_cnt++;
            else if (!tag_hit)
                tag_pos = '0;
            return;
        end
        if (tab_cnt == 2'd2)
        begin
            if (seq_len == 0)
                seq_star = (c == STAR_BYTE);
            if (seq_len <= LEN_MAX)
                seq_len++;
        end
        else if (tab_cnt == 2'd3)
        begin
            if (tag_hit)
            begin
                if (in_digits)
                    take_ln_digit(c);
            end
            else if (tag_pos < TAG_LEN)
            begin
                if (c == LN_TAG[39 - 8 * int'(tag_pos) -: 8])
                    tag_pos++;
                else
                    tag_pos = TAG_MISMATCH;
            end
            else if (tag_pos == TAG_LEN)
            begin
                tag_hit   = 1'b1;
                in_digits = 1'b1;
                take_ln_digit(c);
            end
        end
    endfunction

    // Works out the result of the line that ends now and resets the line state.
    function automatic void close_line();
        result_t     r;
        logic [63:0] len;
        len = '0;
        if (line_fresh || !line_is_seg)
            r.status = ST_NOT_SEGMENT;
        else if (tab_cnt < 2'd2)
            r.status = ST_MISSING;
        else if (!(seq_len == 1 && seq_star))
        begin
            if (seq_len > LEN_MAX)
                r.status = ST_TOO_LARGE;
            else
            begin
                r.status = ST_OK;
                len      = 64'(seq_len);
            end
        end
        else if (tab_cnt < 2'd3)
            r.status = ST_MISSING;
        else if (!tag_hit)
            r.status = ST_NO_TAG;
        else if (!any_digit || ln_overflow)
            r.status = ST_BAD_NUMBER;
        else if (ln_value > LEN_MAX)
            r.status = ST_TOO_LARGE;
        else
        begin
            r.status = ST_OK;
            len      = ln_value;
        end
        r.seg_length = len[31:0];
        line_results.push_back(r);
        clear_line();
    endfunction

    function automatic void predict_request(char_req_t req);
        if (req.byte_valid)
            take_line_byte(req.data_byte);
        if (req.line_end)
            close_line();
    endfunction

    task automatic char_gap(int n);
        repeat (n) @(negedge clk) char_valid <= 1'b0;
    endtask

    task automatic send_char(octet_t b, bit v, bit e);
        char_req_t req;
        req.data_byte  = b;
        req.byte_valid = v;
        req.line_end   = e;
        if (gaps_on && $urandom_range(0, 7) == 0)
            char_gap($urandom_range(1, 17));
        @(negedge clk);
        char_valid <= 1'b1;
        char_req   <= req;
        do
            @(posedge clk);
        while (char_stall);
        predict_request(req);
        if (v || e)
            items_sent++;
    endtask

    // Sends line_buf as one line, ending on its last byte or on a bare end marker.
    task automatic send_line(bit bare_end);
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_char(octet_t'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_char(line_buf[i], 1'b1, !bare_end && i == n - 1);
        end
        if (bare_end || n == 0)
            send_char(octet_t'($urandom_range(0, 255)), 1'b0, 1'b1);
        line_buf.delete();
    endtask

    task automatic send_text(string s, bit bare_end);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(octet_t'(s[i]));
        send_line(bare_end);
    endtask

    task automatic wait_for_results();
        char_gap(1);
        while (line_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(octet_t'(s[i]));
    endfunction

    function automatic octet_t any_but_tab();
        octet_t b;
        b = octet_t'($urandom_range(0, 255));
        while (b == TAB_BYTE)
            b = octet_t'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void put_junk(int n);
        repeat (n) line_buf.push_back(any_but_tab());
    endfunction

    function automatic string number_text();
        logic [63:0] v;
        string       s;
        s = "";
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 999));
            1: v = 64'($urandom());
            2: v = 64'd4294967294 + 64'($urandom_range(0, 3));
            3: v = {$urandom(), $urandom()};
            4: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            5: return $sformatf("1844674407370955161%0d", $urandom_range(0, 9));
            6:
            begin
                repeat ($urandom_range(21, 30)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
                return s;
            end
            default: return $sformatf("000%0d", $urandom_range(0, 99999));
        endcase
        return $sformatf("%0d", v);
    endfunction

    // One tag field after the sequence, half the time LN:i: with a number.
    function automatic void put_tag_field();
        put_text("\t");
        case ($urandom_range(0, 7))
            0: put_text("RC:i:17");
            1: put_text("LN:i:");
            2: put_text("LN:f:3");
            3: put_junk($urandom_range(0, 6));
            default:
            begin
                put_text("LN:i:");
                case ($urandom_range(0, 11))
                    0: put_text("+");
                    1: put_text("-");
                    2: put_text(" ");
                    3: put_junk(1);
                    default: ;
                endcase
                put_text(number_text());
                if ($urandom_range(0, 2) == 0)
                    put_junk($urandom_range(1, 4));
            end
        endcase
    endfunction

    function automatic void put_name();
        put_text("S\t");
        repeat ($urandom_range(0, 4)) line_buf.push_back(octet_t'($urandom_range(8'h41, 8'h7A)));
        put_text("\t");
    endfunction

    function automatic void build_random_line();
        string bases;
        string mix;
        bases = "ACGTN";
        mix   = "S\t*LN:i0123456789";
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                put_name();
                repeat ($urandom_range(0, 24))
                begin
                    if ($urandom_range(0, 5) == 0)
                        line_buf.push_back(any_but_tab());
                    else
                        line_buf.push_back(octet_t'(bases[$urandom_range(0, 4)]));
                end
                repeat ($urandom_range(0, 2)) put_tag_field();
            end
            3, 4, 5, 6:
            begin
                put_name();
                put_text("*");
                repeat ($urandom_range(0, 3)) put_tag_field();
                if ($urandom_range(0, 7) == 0)
                    put_text("\t");
            end
            7:
            begin
                line_buf.push_back(any_but_tab());
                if (line_buf[0] == SEG_BYTE)
                    line_buf[0] = 8'hFF;
                put_text("\tx\t*\tLN:i:9");
            end
            default:
            begin
                repeat ($urandom_range(0, 14))
                begin
                    if ($urandom_range(0, 3) == 0)
                        line_buf.push_back(octet_t'($urandom_range(0, 255)));
                    else
                        line_buf.push_back(octet_t'(mix[$urandom_range(0, mix.len() - 1)]));
                end
            end
        endcase
    endfunction

    task automatic test_directed_lines();
        send_text("", 1'b1);
        send_text("A\tx\tACG", 1'b0);
        send_text("S", 1'b0);
        send_text("S\tx", 1'b1);
        send_text("S\tx\tACGT", 1'b0);
        send_text("S\tx\t", 1'b1);
        send_text("S\tx\t**", 1'b0);
        send_text("S\tx\t*", 1'b0);
        send_text("S\tx\t*\tRC:i:3", 1'b0);
        send_text("S\tx\t*\tLN:i:", 1'b1);
        send_text("S\tx\t*\tLN:i:-5", 1'b0);
        send_text("S\tx\t*\tLN:i: 5", 1'b0);
        send_text("S\tx\t*\tLN:i:12ab", 1'b0);
        send_text("S\tx\t*\tLN:i:x\tLN:i:7", 1'b0);
        send_text("S\tx\t*\tLN:i:\tLN:i:7", 1'b1);
        send_text("S\tx\t*\tLN:i:4294967295", 1'b0);
        send_text("S\tx\t*\tLN:i:4294967296", 1'b0);
        send_text("S\tx\t*\tLN:i:18446744073709551615", 1'b0);
        send_text("S\tx\t*\tLN:i:18446744073709551616", 1'b0);
        // Extreme byte values inside the sequence and as the first byte.
        send_char(8'hFF, 1'b0, 1'b0);
        put_text("S\tx\t");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line(1'b0);
        line_buf.push_back(8'hFF);
        send_line(1'b0);
        wait_for_results();
    endtask

    // The receiver holds off while short lines keep coming, so the input backs up.
    task automatic test_input_backpressure();
        gaps_on = 1'b0;
        rx_hold = 300;
        repeat (12) send_text("S\tn\tAC", 1'b0);
        gaps_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        repeat (4)
        begin
            build_random_line();
            send_line($urandom_range(0, 3) == 0);
        end
        wait_for_results();
        send_text("S\tp\t*\tLN:i:42", 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_lines();
        while (items_sent < ITEM_GOAL - 150)
        begin
            build_random_line();
            send_line($urandom_range(0, 3) == 0);
        end
        wait_for_results();
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_steady_stream();
        gaps_on  = 1'b0;
        rx_quiet = 1'b1;
        while (items_sent < ITEM_GOAL)
        begin
            build_random_line();
            send_line($urandom_range(0, 3) == 0);
        end
        wait_for_results();
    endtask

    // Result side: random stall bursts, free stretches, and the long hold-off.
    initial
    begin
        int burst_left;
        bit burst_stall;
        burst_left   = 0;
        burst_stall  = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                result_stall <= 1'b1;
                rx_hold--;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_stall = !rx_quiet && $urandom_range(0, 2) == 0;
                    burst_left  = $urandom_range(1, 17);
                end
                result_stall <= burst_stall;
                burst_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (line_results.size() == 0)
            begin
                $display("%0t: unexpected result, seg_length %0d status %0d", $time,
                         result_data.seg_length, result_data.status);
                errors++;
            end
            else
            begin
                want = line_results.pop_front();
                if (result_data.seg_length !== want.seg_length)
                begin
                    $display("%0t: seg_length expected %0d actual %0d", $time,
                             want.seg_length, result_data.seg_length);
                    errors++;
                end
                if (result_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, result_data.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clear_line();
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_req   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_directed_lines();
        test_input_backpressure();
        test_sender_pause();
        test_random_lines();
        test_steady_stream();
        repeat (8) @(posedge clk);
        if (errors == 0 && line_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
